// ----- sv/rpa_pkg.sv -----
// Shared constants for the reference-counted page allocator.
// Action and status codes, field widths and parameter defaults.
// No dependencies.
package rpa_pkg;

   localparam int PAGE_W      = 15;   // page field width on the ports
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int OUT_COUNT_W = 8;    // count field width on the ports
   localparam int CMP_W       = 17;   // wide enough for any page bound
   localparam int CNT_EXT_W   = 16;   // largest count width

   localparam int DEF_NUM_PAGES  = 32768;
   localparam int DEF_COUNT_BITS = 8;

   localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ADDREF = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOFREE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_UNREF  = 2'd3;

endpackage

// ----- sv/refcounted_page_allocator.sv -----
// Page allocator: LIFO free list plus per-page reference counts.
// Uses rpa_pkg; count and link memories live inside this module.
// An accepted item enters the lookup state, and its result is registered as it
// leaves; a stalled result holds the lookup state until the output slot frees.
// No new item is taken until the lookup ends, set by the read then write-back of
// the count and link memories (one read and one write port each).
// Reset is synchronous; no clearing pass: pages not yet handed out since the
// last rebuild are tracked by a watermark, so an item is taken right after reset.
module refcounted_page_allocator
   import rpa_pkg::*;
#(
   parameter int NUM_PAGES  = DEF_NUM_PAGES,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: first_usable_page
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data,
   // requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [14:0] page_number, [15] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [14:0] page_number_out, [22:15] ref_count_after, [23] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int IMP_W = IDX_W + 1;

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_LOOKUP = 1'b1;

   localparam logic [CMP_W-1:0]      NUM_PAGES_W = CMP_W'(NUM_PAGES);
   localparam logic [COUNT_BITS-1:0] CNT_MAX     = '1;

   // memories
   logic [COUNT_BITS-1:0] count_mem [NUM_PAGES];
   logic [IDX_W-1:0]      link_mem  [NUM_PAGES];

   logic                  state_ff, state_in;
   logic [ACTION_W-1:0]   act_ff;
   logic [PAGE_W-1:0]     page_ff;
   logic [PAGE_W-1:0]     first_ff;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IMP_W-1:0]      free_cnt_ff, free_cnt_in;
   logic [IMP_W-1:0]      imp_ff, imp_in;      // pages in [first, imp) untouched
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [IDX_W-1:0]      link_rd_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]     rsp_page_ff, rsp_page_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [OUT_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                  accept;
   logic                  lookup_done;
   logic [CMP_W-1:0]      req_page_ext;
   logic [IDX_W-1:0]      rd_addr;
   logic [CMP_W-1:0]      pg_ext;
   logic [IDX_W-1:0]      pg_idx;
   logic                  pg_in_range;
   logic [COUNT_BITS-1:0] cur_cnt;
   logic [COUNT_BITS-1:0] new_cnt;
   logic [CNT_EXT_W-1:0]  cnt_wide;
   logic                  head_implicit;
   logic [CMP_W-1:0]      first_ext;
   logic [IMP_W-1:0]      init_free_cnt;

   logic                  cnt_we;
   logic [IDX_W-1:0]      cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic                  link_we;

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = (state_ff == S_IDLE);
   assign lookup_done = (state_ff == S_LOOKUP) && (!rsp_valid_ff || rsp_tready);

   assign req_page_ext = {2'b00, req_tdata[PAGE_W-1:0]};
   assign rd_addr      = (req_tuser == ACT_ALLOC) ? head_ff : req_page_ext[IDX_W-1:0];

   assign pg_ext      = {2'b00, page_ff};
   assign pg_idx      = pg_ext[IDX_W-1:0];
   assign pg_in_range = (page_ff >= first_ff) && (pg_ext < NUM_PAGES_W);
   // an untouched page has never been handed out, so its count is zero
   assign cur_cnt       = ({1'b0, pg_idx} >= imp_ff) ? cnt_rd_ff : '0;
   assign head_implicit = ({1'b0, head_ff} < imp_ff);

   assign first_ext     = {2'b00, csr_wr_data};
   assign init_free_cnt = (first_ext < NUM_PAGES_W) ?
                          IMP_W'(NUM_PAGES_W - first_ext) : '0;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      free_cnt_in   = free_cnt_ff;
      imp_in        = imp_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      cnt_we        = 1'b0;
      cnt_waddr     = pg_idx;
      cnt_wdata     = '0;
      link_we       = 1'b0;
      new_cnt       = '0;
      cnt_wide      = '0;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         state_in = S_LOOKUP;
      end

      if (lookup_done) begin
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_page_in   = page_ff;
         rsp_status_in = STAT_OK;
         case (act_ff)
            ACT_ALLOC: begin
               if (free_cnt_ff == '0) begin
                  rsp_status_in = STAT_NOFREE;
                  rsp_page_in   = '0;
               end else begin
                  rsp_page_in = PAGE_W'({{CMP_W{1'b0}}, head_ff});
                  new_cnt     = COUNT_BITS'(1);
                  cnt_we      = 1'b1;
                  cnt_waddr   = head_ff;
                  cnt_wdata   = new_cnt;
                  free_cnt_in = free_cnt_ff - IMP_W'(1);
                  if (head_implicit) begin
                     // untouched region pops in descending order
                     head_in = head_ff - IDX_W'(1);
                     imp_in  = {1'b0, head_ff};
                  end else begin
                     head_in = link_rd_ff;
                  end
               end
            end
            ACT_FREE, ACT_ADDREF: begin
               if (!pg_in_range) begin
                  rsp_status_in = STAT_RANGE;
               end else if (cur_cnt == '0) begin
                  rsp_status_in = STAT_UNREF;
               end else begin
                  cnt_we = 1'b1;
                  if (act_ff == ACT_FREE) begin
                     new_cnt = cur_cnt - COUNT_BITS'(1);
                     if (new_cnt == '0) begin
                        // last reference gone: push onto the list
                        link_we     = 1'b1;
                        head_in     = pg_idx;
                        free_cnt_in = free_cnt_ff + IMP_W'(1);
                     end
                  end else begin
                     new_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
                  end
                  cnt_wdata = new_cnt;
               end
            end
            default: begin
            end
         endcase
         cnt_wide     = CNT_EXT_W'(new_cnt);
         rsp_count_in = cnt_wide[OUT_COUNT_W-1:0];
      end

      if (csr_wr_en) begin
         head_in     = IDX_W'(NUM_PAGES - 1);
         imp_in      = IMP_W'(NUM_PAGES);
         free_cnt_in = init_free_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         first_ff     <= '0;
         head_ff      <= IDX_W'(NUM_PAGES - 1);
         imp_ff       <= IMP_W'(NUM_PAGES);
         free_cnt_ff  <= IMP_W'(NUM_PAGES);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         imp_ff       <= imp_in;
         free_cnt_ff  <= free_cnt_in;
         if (csr_wr_en) begin
            first_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= req_tuser;
         page_ff <= req_tdata[PAGE_W-1:0];
      end
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // count memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
      if (accept) begin
         cnt_rd_ff <= count_mem[rd_addr];
      end
   end

   // link memory
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[pg_idx] <= head_ff;
      end
      if (accept) begin
         link_rd_ff <= link_mem[head_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_page_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- sv/rpa_checker.sv -----
// Port-level checks for refcounted_page_allocator, bound into refcounted_page_allocator.
// Uses rpa_pkg for status codes.
module rpa_checker
   import rpa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one item in flight: no accept in the lookup cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted during lookup");

   // every accepted item finds a result valid after its lookup
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("result missing after item");

   // refused actions report a zero count; empty list reports page zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_NOFREE || rsp_tuser == STAT_RANGE ||
                     rsp_tuser == STAT_UNREF)
      |-> rsp_tdata[22:15] == 8'd0 &&
          (rsp_tuser != STAT_NOFREE || rsp_tdata[14:0] == 15'd0))
      else $error("refused action with non-zero fields");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (.*);

// ----- bench/tb_refcounted_page_allocator.sv -----
// Self-checking bench for refcounted_page_allocator: free-list allocation, reference
// counting, range and double-free refusal, saturation and re-initialisation by register.
// Depends on rpa_pkg and the allocator RTL only.
module tb_refcounted_page_allocator;
   import rpa_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int COUNT_MAX = (1 << DEF_COUNT_BITS) - 1;
   localparam int FIRST_HIGHEST = 32767;

   typedef struct packed {
      logic [PAGE_W-1:0]      page;
      logic [STATUS_W-1:0]    status;
      logic [OUT_COUNT_W-1:0] count;
   } page_result_type;

   class page_ledger_type;
      int unsigned first_page;
      int unsigned head;
      int unsigned on_list;
      int unsigned link [DEF_NUM_PAGES];
      int unsigned refs [DEF_NUM_PAGES];
      page_result_type awaited [$];
      int errors;

      function new();
         errors = 0;
         rebuild(0);
      endfunction

      // counts cleared, list rebuilt with the highest page on top
      function void rebuild(int unsigned first);
         first_page = first;
         head = 0;
         on_list = 0;
         for (int p = 0; p < DEF_NUM_PAGES; p++) begin
            refs[p] = 0;
            link[p] = 0;
         end
         for (int p = first; p < DEF_NUM_PAGES; p++) begin
            if (on_list != 0) link[p] = head;
            head = p;
            on_list++;
         end
      endfunction

      function int unsigned refs_of(logic [PAGE_W-1:0] page);
         return refs[page];
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function page_result_type note_request(logic [ACTION_W-1:0] act,
                                             logic [PAGE_W-1:0] page);
         page_result_type r;
         int unsigned c;
         r.page = page;
         r.status = STAT_OK;
         r.count = '0;
         case (act)
            ACT_ALLOC: begin
               if (on_list == 0) begin
                  r.status = STAT_NOFREE;
                  r.page = '0;
               end else begin
                  r.page = head[PAGE_W-1:0];
                  refs[head] = 1;
                  head = link[head];
                  on_list--;
                  r.count = OUT_COUNT_W'(1);
               end
            end
            ACT_FREE, ACT_ADDREF: begin
               if (page < first_page || int'(page) >= DEF_NUM_PAGES) begin
                  r.status = STAT_RANGE;
               end else if (refs[page] == 0) begin
                  r.status = STAT_UNREF;
               end else if (act == ACT_FREE) begin
                  c = refs[page] - 1;
                  refs[page] = c;
                  if (c == 0) begin
                     if (on_list != 0) link[page] = head;
                     head = page;
                     on_list++;
                  end
                  r.count = c[OUT_COUNT_W-1:0];
               end else begin
                  c = refs[page];
                  if (c < COUNT_MAX) c++;
                  refs[page] = c;
                  r.count = c[OUT_COUNT_W-1:0];
               end
            end
            default: ;
         endcase
         awaited.push_back(r);
         return r;
      endfunction

      task report(string what, int got, int want);
         if (errors < 100)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
         errors++;
      endtask

      task check_result(logic [PAGE_W-1:0] page, logic [STATUS_W-1:0] status,
                        logic [OUT_COUNT_W-1:0] count);
         page_result_type w;
         if (awaited.size() == 0) begin
            report("unexpected result page", page, -1);
         end else begin
            w = awaited.pop_front();
            if (page !== w.page) report("page_number_out", page, w.page);
            if (status !== w.status) report("status", status, w.status);
            if (count !== w.count) report("ref_count_after", count, w.count);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [14:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [14:0] page_number, [15] zero
   logic [1:0]  req_tuser = '0;    // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [14:0] page_number_out, [22:15] ref_count_after, [23] zero
   logic [1:0]  rsp_tuser;         // [1:0] status

   page_ledger_type ledger = new();
   logic [PAGE_W-1:0] held_pages [$];
   int burst_left = 0;
   int ready_pct = 100;
   int rx_cycle = 0;

   refcounted_page_allocator u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // receiver: random readiness level, from never stalling to mostly stalled
   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) begin
         case ($urandom_range(0, 4))
            0, 1: ready_pct = 100;
            2: ready_pct = 75;
            3: ready_pct = 40;
            default: ready_pct = 10;
         endcase
      end
      rsp_tready <= ($urandom_range(0, 99) < ready_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_result(rsp_tdata[14:0], rsp_tuser, rsp_tdata[22:15]);
   end

   // one item, held until taken; bursts of random length with random gaps between them
   task issue(logic [ACTION_W-1:0] act, logic [PAGE_W-1:0] page, output page_result_type r);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, page};
      req_tuser <= act;
      do @(posedge clock); while (!req_tready);
      r = ledger.note_request(act, page);
      if (act == ACT_ALLOC && r.status == STAT_OK) held_pages.push_back(r.page);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task send(logic [ACTION_W-1:0] act, logic [PAGE_W-1:0] page);
      page_result_type r;
      issue(act, page, r);
   endtask

   task drain();
      req_tvalid <= 1'b0;
      while (ledger.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task set_first_page(logic [14:0] first);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= first;
      @(posedge clock);
      ledger.rebuild(first);
      held_pages.delete();
      csr_wr_en <= 1'b0;
   endtask

   // a live page from those handed out, dropping stale entries on the way
   function bit pick_held(output logic [PAGE_W-1:0] page);
      int idx;
      page = '0;
      while (held_pages.size() > 0) begin
         idx = $urandom_range(0, held_pages.size() - 1);
         page = held_pages[idx];
         if (ledger.refs_of(page) > 0) return 1'b1;
         held_pages.delete(idx);
      end
      return 1'b0;
   endfunction

   task random_items(int n);
      int sel;
      logic [PAGE_W-1:0] page;
      logic [ACTION_W-1:0] act;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         page = PAGE_W'($urandom_range(0, 32767));
         act = ($urandom_range(0, 1) == 0) ? ACT_FREE : ACT_ADDREF;
         if (sel < 35) begin
            act = ACT_ALLOC;
         end else if (sel < 80) begin
            if (!pick_held(page)) act = ACT_ALLOC;
            else act = (sel < 60) ? ACT_FREE : ACT_ADDREF;
         end else if (sel < 94) begin
            // some below the usable range where there is one, the rest anywhere
            if (sel >= 88 && ledger.first_page > 0)
               page = PAGE_W'($urandom_range(0, ledger.first_page - 1));
         end else begin
            act = ACT_UNUSED;
         end
         send(act, page);
      end
   endtask

   // drive one page's count into saturation and back down past zero
   task saturate_one();
      page_result_type r;
      issue(ACT_ALLOC, PAGE_W'($urandom_range(0, 32767)), r);
      repeat (COUNT_MAX + 5) send(ACT_ADDREF, r.page);
      repeat (COUNT_MAX + 5) send(ACT_FREE, r.page);
   endtask

   initial begin
      int firsts [5] = '{32760, 0, FIRST_HIGHEST, 32000, 32740};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // whole range usable after reset
      send(ACT_ALLOC, 15'h7FFF);
      send(ACT_ALLOC, 15'h0000);
      send(ACT_ADDREF, 15'h7FFF);
      send(ACT_FREE, 15'h7FFF);
      send(ACT_FREE, 15'h7FFF);
      send(ACT_FREE, 15'h7FFF);     // double free
      send(ACT_ADDREF, 15'h7FFF);   // reference to a page on the list
      send(ACT_ALLOC, 15'h5555);    // last freed comes back first
      send(ACT_FREE, 15'h0000);
      send(ACT_ADDREF, 15'h0000);
      send(ACT_UNUSED, 15'h5555);
      send(ACT_UNUSED, 15'h2AAA);

      // single usable page
      set_first_page(PAGE_W'(FIRST_HIGHEST));
      send(ACT_FREE, 15'h0000);
      send(ACT_ADDREF, 15'h7FFE);
      send(ACT_ALLOC, 15'h0000);
      send(ACT_ALLOC, 15'h7FFF);    // list empty
      send(ACT_ADDREF, 15'h7FFF);
      send(ACT_FREE, 15'h7FFF);
      send(ACT_FREE, 15'h7FFF);
      send(ACT_ALLOC, 15'h1234);
      send(ACT_FREE, 15'h7FFF);
      send(ACT_FREE, 15'h7FFF);

      foreach (firsts[k]) begin
         set_first_page(PAGE_W'(firsts[k]));
         if (k == 0) saturate_one();
         random_items(110);
         drain();
         random_items(110);
      end

      drain();
      repeat (10) @(posedge clock);
      if (ledger.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
